>>> src/cuckoo_filter_engine_assert.svh
// ----------------------------------------------------------------------------
// Cuckoo filter engine assertion macros
// Macros for the concurrent checks in the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef CUCKOO_FILTER_ENGINE_ASSERT_SVH
`define CUCKOO_FILTER_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/cfe_pkg.sv
// ----------------------------------------------------------------------------
// Cuckoo filter engine package
// Operation codes, hash constants and the 16-bit djb hash.
// ----------------------------------------------------------------------------
package cfe_pkg;

   // Width of a fingerprint and of a key.
   localparam int FP_W = 16;

   // Operation codes carried by a request beat.
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // djb hash constants.
   localparam int DJB_SEED  = 5381;
   localparam int DJB_MULT  = 33;
   localparam int HASH_MASK = 'hFFFF;

   // The seed passes through both multiply steps; fold it into one constant.
   localparam logic [15:0] DJB_BASE = 16'((DJB_SEED * DJB_MULT * DJB_MULT) & HASH_MASK);

   // djb hash over the two bytes of a 16-bit value, low byte first, kept to
   // 16 bits: base + 33 * low byte + high byte.
   function automatic logic [15:0] djb16(input logic [15:0] value);
      logic [15:0] lo_byte;
      logic [15:0] hi_byte;
      lo_byte = {8'd0, value[7:0]};
      hi_byte = {8'd0, value[15:8]};
      return DJB_BASE + (lo_byte << 5) + lo_byte + hi_byte;
   endfunction

endpackage

>>> src/cfe_req_if.sv
// ----------------------------------------------------------------------------
// Cuckoo filter engine request channel
// Valid/ready channel that carries one operation beat.
// ----------------------------------------------------------------------------
interface cfe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] key;
   logic        evict_first;

   modport source (output valid, output operation, output key, output evict_first,
                   input ready);
   modport sink   (input valid, input operation, input key, input evict_first,
                   output ready);
endinterface

>>> src/cfe_rsp_if.sv
// ----------------------------------------------------------------------------
// Cuckoo filter engine response channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface cfe_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [15:0] lost_fingerprint;

   modport source (output valid, output ok, output lost_fingerprint, input ready);
   modport sink   (input valid, input ok, input lost_fingerprint, output ready);
endinterface

>>> src/cuckoo_filter_engine.sv
// ----------------------------------------------------------------------------
// Cuckoo filter engine
// Lookup, insert and clear on a cuckoo filter with one 16-bit fingerprint
// per bucket, kept in a single-port-read, single-port-write memory.
//
//   Channel   Dir   Beat contents
//   req_chan  in    operation, key, evict_first
//   rsp_chan  out   ok, lost_fingerprint
//   csr_*     in    relocation_limit (7 bits, written when csr_write_enable)
//
// A lookup or an insert into a free bucket passes through S_FP, S_RD1, S_RD2,
// S_DEC and S_RESP, then the response register; each victim relocation adds
// a read, then a swap (S_RREQ, S_RDAT), through the single memory read port.
// A clear sweeps the store, one bucket written a cycle, then gives a result.
// After reset the same clearing pass runs, with req_chan.ready low. One item
// is in work at a time; a waiting result beat holds the engine in its result
// state until rsp_chan.ready.
// ----------------------------------------------------------------------------
module cuckoo_filter_engine #(
   parameter int BUCKET_COUNT = 128
) (
   input  logic        clock,
   input  logic        reset,
   cfe_req_if.sink     req_chan,
   cfe_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   localparam int IDX_W = $clog2(BUCKET_COUNT);
   localparam logic [6:0] LIMIT_RESET = 7'd8;

   logic [6:0]       relocation_limit_ff, relocation_limit_in;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [15:0]      mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   logic [15:0]      mem_rdata;

   // Relocation limit register.
   assign relocation_limit_in = csr_write_enable ? csr_write_data : relocation_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relocation_limit_ff <= LIMIT_RESET;
      end else begin
         relocation_limit_ff <= relocation_limit_in;
      end
   end

   // Bucket store.
   cfe_bucket_ram #(
      .DEPTH  (BUCKET_COUNT),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Sequencer.
   cfe_ctrl #(
      .BUCKET_COUNT (BUCKET_COUNT),
      .IDX_W        (IDX_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .relocation_limit (relocation_limit_ff),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

endmodule

>>> src/cfe_bucket_ram.sv
// ----------------------------------------------------------------------------
// Cuckoo filter bucket memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfe_bucket_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] store_ff [DEPTH];
   logic [15:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data is registered and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/cfe_ctrl.sv
// ----------------------------------------------------------------------------
// Cuckoo filter controller
// Sequencer that hashes a key, reads both candidate buckets, decides, walks
// the relocation chain through the bucket memory, and clears the store.
// ----------------------------------------------------------------------------
`include "cuckoo_filter_engine_assert.svh"

module cfe_ctrl #(
   parameter int BUCKET_COUNT = 128,
   parameter int IDX_W        = 7
) (
   input  logic             clock,
   input  logic             reset,
   cfe_req_if.sink          req,
   cfe_rsp_if.source        rsp,
   input  logic [6:0]       relocation_limit,
   output logic             mem_we,
   output logic [IDX_W-1:0] mem_waddr,
   output logic [15:0]      mem_wdata,
   output logic [IDX_W-1:0] mem_raddr,
   input  logic [15:0]      mem_rdata
);

   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(BUCKET_COUNT - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKET_COUNT - 1);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_FP    = 9'b000000100,
      S_RD1   = 9'b000001000,
      S_RD2   = 9'b000010000,
      S_DEC   = 9'b000100000,
      S_RREQ  = 9'b001000000,
      S_RDAT  = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic             clr_op_ff, clr_op_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [1:0]       op_ff, op_in;
   logic [15:0]      key_ff, key_in;
   logic             evict_ff, evict_in;
   logic [15:0]      fp_ff, fp_in;
   logic [IDX_W-1:0] i1_ff, i1_in;
   logic [IDX_W-1:0] i2_ff, i2_in;
   logic [15:0]      b1_ff, b1_in;
   logic [IDX_W-1:0] vidx_ff, vidx_in;
   logic [15:0]      victim_ff, victim_in;
   logic [6:0]       count_ff, count_in;
   logic             res_ok_ff, res_ok_in;
   logic [15:0]      res_lost_ff, res_lost_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [15:0]      rsp_lost_ff, rsp_lost_in;

   logic [15:0]      fp_calc;
   logic [15:0]      fp_hash;
   logic [15:0]      victim_hash;
   logic [IDX_W-1:0] i1_calc;
   logic [IDX_W-1:0] i2_calc;
   logic [IDX_W-1:0] alt_idx;
   logic [7:0]       count_next;
   logic             limit_reached;
   logic             out_free;
   logic             rsp_load;

   // Hashes and bucket indexes, each taken from a registered value.
   assign fp_calc       = cfe_pkg::djb16(key_ff);
   assign fp_hash       = cfe_pkg::djb16(fp_ff);
   assign victim_hash   = cfe_pkg::djb16(victim_ff);
   assign i1_calc       = fp_ff[IDX_W-1:0] & IDX_MASK;
   assign i2_calc       = (i1_calc ^ (fp_hash[IDX_W-1:0] & IDX_MASK)) & IDX_MASK;
   assign alt_idx       = (vidx_ff ^ (victim_hash[IDX_W-1:0] & IDX_MASK)) & IDX_MASK;
   assign count_next    = {1'b0, count_ff} + 8'd1;
   assign limit_reached = count_next >= {1'b0, relocation_limit};
   assign out_free      = !rsp_valid_ff || rsp.ready;

   assign req.ready            = (state_ff == S_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.ok               = rsp_ok_ff;
   assign rsp.lost_fingerprint = rsp_lost_ff;

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      clr_op_in   = clr_op_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      evict_in    = evict_ff;
      fp_in       = fp_ff;
      i1_in       = i1_ff;
      i2_in       = i2_ff;
      b1_in       = b1_ff;
      vidx_in     = vidx_ff;
      victim_in   = victim_ff;
      count_in    = count_ff;
      res_ok_in   = res_ok_ff;
      res_lost_in = res_lost_ff;
      rsp_load    = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = vidx_ff;
      mem_wdata   = '0;
      mem_raddr   = i1_calc;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep zeros through the store, one bucket a cycle.
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_LAST) begin
               clr_addr_in = '0;
               clr_op_in   = 1'b0;
               if (clr_op_ff) begin
                  res_ok_in   = 1'b1;
                  res_lost_in = '0;
                  state_in    = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_IDLE: begin
            if (req.valid) begin
               op_in    = req.operation;
               key_in   = req.key;
               evict_in = req.evict_first;
               unique case (req.operation)
                  cfe_pkg::OP_LOOKUP, cfe_pkg::OP_INSERT: begin
                     state_in = S_FP;
                  end
                  cfe_pkg::OP_CLEAR: begin
                     clr_op_in = 1'b1;
                     state_in  = S_CLEAR;
                  end
                  default: begin
                     res_ok_in   = 1'b0;
                     res_lost_in = '0;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end

         S_FP: begin
            fp_in    = fp_calc;
            state_in = S_RD1;
         end

         S_RD1: begin
            // Read the first candidate.
            mem_raddr = i1_calc;
            i1_in     = i1_calc;
            i2_in     = i2_calc;
            state_in  = S_RD2;
         end

         S_RD2: begin
            // Read the second candidate while the first arrives.
            mem_raddr = i2_ff;
            b1_in     = mem_rdata;
            state_in  = S_DEC;
         end

         S_DEC: begin
            res_lost_in = '0;
            state_in    = S_RESP;
            if (op_ff == cfe_pkg::OP_LOOKUP) begin
               res_ok_in = (b1_ff == fp_ff) || (mem_rdata == fp_ff);
            end else if (b1_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = i1_ff;
               mem_wdata = fp_ff;
               res_ok_in = 1'b1;
            end else if (mem_rdata == '0) begin
               mem_we    = 1'b1;
               mem_waddr = i2_ff;
               mem_wdata = fp_ff;
               res_ok_in = 1'b1;
            end else begin
               // Both full: place the new fingerprint and start the chain.
               vidx_in   = evict_ff ? i1_ff : i2_ff;
               victim_in = evict_ff ? b1_ff : mem_rdata;
               mem_we    = 1'b1;
               mem_waddr = vidx_in;
               mem_wdata = fp_ff;
               count_in  = '0;
               state_in  = S_RREQ;
            end
         end

         S_RREQ: begin
            // Read the victim's alternate bucket; the last write has landed.
            mem_raddr = alt_idx;
            vidx_in   = alt_idx;
            state_in  = S_RDAT;
         end

         S_RDAT: begin
            // Swap the victim in and carry out the old occupant.
            mem_we    = 1'b1;
            mem_waddr = vidx_ff;
            mem_wdata = victim_ff;
            victim_in = mem_rdata;
            count_in  = count_next[6:0];
            if (mem_rdata == '0) begin
               res_ok_in   = 1'b1;
               res_lost_in = '0;
               state_in    = S_RESP;
            end else if (limit_reached) begin
               res_ok_in   = 1'b0;
               res_lost_in = mem_rdata;
               state_in    = S_RESP;
            end else begin
               state_in = S_RREQ;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_lost_in  = rsp_lost_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_lost_in  = res_lost_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_op_ff    <= clr_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      evict_ff    <= evict_in;
      fp_ff       <= fp_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      b1_ff       <= b1_in;
      vidx_ff     <= vidx_in;
      victim_ff   <= victim_in;
      count_ff    <= count_in;
      res_ok_ff   <= res_ok_in;
      res_lost_ff <= res_lost_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_lost_ff <= rsp_lost_in;
   end

   // The store is never written while the engine waits for work.
   `CFE_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == S_IDLE, !mem_we, "write while idle")
   // An accepted beat always starts work.
   `CFE_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req.valid && req.ready, state_ff != S_IDLE, "accept did not start work")
   // The relocation count stays below the limit, or at zero, while the chain runs.
   `CFE_ASSERT_NOW(a_count_bound, clock, reset, state_ff == S_RDAT, count_ff == '0 || count_ff < relocation_limit, "relocation count beyond limit")
   // A finished result reaches the response register.
   `CFE_ASSERT_NEXT(a_result_shown, clock, reset, state_ff == S_RESP && out_free, rsp_valid_ff, "result not presented")

endmodule
